// ===== rtl/sspt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Socket slot table package
// Shared operation codes, field widths, hash constants and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sspt_pkg;

   localparam int KIND_W  = 2;
   localparam int OWNER_W = 16;
   localparam int SLOT_W  = 5;
   localparam int PORT_W  = 16;
   localparam int TIME_W  = 64;

   // Ephemeral ports live in the upper half of the port space.
   localparam logic [PORT_W-1:0] EPH_BASE = 16'h8000;
   localparam int                EPH_BITS = 15;

   localparam logic [63:0] HASH_MUL    = 64'd2685821657736338717;
   localparam logic [31:0] HASH_MUL_LO = HASH_MUL[31:0];
   localparam logic [31:0] HASH_MUL_HI = HASH_MUL[63:32];

   typedef enum logic [KIND_W-1:0] {
      OP_OPEN        = 2'd0,
      OP_CLOSE       = 2'd1,
      OP_CLOSE_OWNER = 2'd2,
      OP_BIND        = 2'd3
   } op_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_OPEN_SCAN,
      ST_OWNER_SCAN,
      ST_HASH,
      ST_PORT_SCAN,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load;        // capture the accepted request word
      logic scan_start;  // begin a sweep over all slots
      logic scan_stop;   // abandon the sweep in progress
      logic wr_open;     // claim the slot under the scan
      logic clr_slot;    // free the requested slot
      logic clr_hit;     // free the slot under the scan
      logic wr_bind;     // bind the candidate port to the requested slot
      logic cand_req;    // candidate port comes from the request
      logic cand_hash;   // candidate port comes from the hash unit
      logic hash_start;  // start a hash round
      logic hash_reseed; // seed the round with the previous hash
      logic res_wr;      // record the result of the operation
      logic res_ok;
      logic publish;     // move the result into the output register
   } sspt_cmd_type;

   typedef struct packed {
      op_kind_type kind;
      logic        owner_zero;
      logic        slot_ok;
      logic        preq_zero;
      logic        hit;
      logic        last;
      logic        hash_done;
      logic        rsp_free;
   } sspt_sts_type;

endpackage
`default_nettype wire

// ===== rtl/sspt_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ephemeral port hash unit
// Xorshift mix followed by a 64-bit multiply by a constant, built from one
// shared 32x32 multiplier, with the cross products added into the upper half.
// ----------------------------------------------------------------------------
module sspt_hash
   import sspt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              reseed,
   input  wire logic [TIME_W-1:0] seed_time,
   output logic                   done,
   output logic [63:0]            hash
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;

   logic [63:0] seed, mix_a, mix_b;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   always_comb begin
      seed  = reseed ? acc_ff : seed_time;
      mix_a = seed ^ (seed >> 12);
      mix_b = mix_a ^ (mix_a << 25);
      x_in  = start ? (mix_b ^ (mix_b >> 27)) : x_ff;

      case (phase_ff)
         2'd0: begin
            mul_a = x_ff[31:0];
            mul_b = HASH_MUL_LO;
         end
         2'd1: begin
            mul_a = x_ff[31:0];
            mul_b = HASH_MUL_HI;
         end
         default: begin
            mul_a = x_ff[63:32];
            mul_b = HASH_MUL_LO;
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);

      // The cross products only reach the upper half modulo 2^64.
      acc_in = acc_ff;
      if (busy_ff) begin
         if (phase_ff == 2'd0) begin
            acc_in = prod;
         end else begin
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         end
      end

      done_in  = busy_ff && (phase_ff == 2'd2);
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 2'd0;
      end else if (busy_ff) begin
         if (phase_ff == 2'd2) begin
            busy_in = 1'b0;
         end
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign hash = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/sspt_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Socket slot table datapath
// Owner and port memories with per-entry valid bits, the slot scan pipeline,
// the candidate port, the hash unit and the result registers.
// ----------------------------------------------------------------------------
module sspt_dpath
   import sspt_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sspt_cmd_type       cmd,
   output sspt_sts_type            sts,
   input  wire logic [KIND_W-1:0]  req_kind,
   input  wire logic [OWNER_W-1:0] req_owner_id,
   input  wire logic [SLOT_W-1:0]  req_slot,
   input  wire logic [PORT_W-1:0]  req_port_request,
   input  wire logic [TIME_W-1:0]  req_time_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic [SLOT_W-1:0]       rsp_slot_out,
   output logic [PORT_W-1:0]       rsp_port_out
);

   localparam int          IDX_W   = $clog2(SLOTS);
   localparam logic [31:0] SLOTS_U = 32'(SLOTS);

   // Captured request word.
   op_kind_type        op_kind_ff, op_kind_in;
   logic [OWNER_W-1:0] op_owner_ff, op_owner_in;
   logic [SLOT_W-1:0]  op_slot_ff, op_slot_in;
   logic [PORT_W-1:0]  op_preq_ff, op_preq_in;
   logic [TIME_W-1:0]  op_time_ff, op_time_in;
   logic [PORT_W-1:0]  cand_ff, cand_in;

   // Scan pipeline: issue stage and registered read stage.
   logic             issue_ff, issue_in;
   logic [IDX_W-1:0] iss_idx_ff, iss_idx_in;
   logic             dv_ff, dv_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [OWNER_W-1:0] own_rd_ff;
   logic [PORT_W-1:0]  port_rd_ff;
   logic               own_rv_ff, port_rv_ff;

   logic [SLOTS-1:0] own_vld_ff, own_vld_in;
   logic [SLOTS-1:0] port_vld_ff, port_vld_in;

   logic [OWNER_W-1:0] own_mem [SLOTS];
   logic [PORT_W-1:0]  port_mem [SLOTS];

   logic              res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [PORT_W-1:0] res_port_ff, res_port_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;

   logic               hash_done;
   logic [63:0]        hash;
   logic [IDX_W-1:0]   slot_addr;
   logic [OWNER_W-1:0] owner_val;
   logic [PORT_W-1:0]  port_val;
   logic               match;

   sspt_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.hash_start),
      .reseed    (cmd.hash_reseed),
      .seed_time (op_time_ff),
      .done      (hash_done),
      .hash      (hash)
   );

   always_comb begin
      slot_addr = IDX_W'(op_slot_ff);
      // Entries never written since reset read as zero.
      owner_val = own_rv_ff ? own_rd_ff : '0;
      port_val  = port_rv_ff ? port_rd_ff : '0;

      case (op_kind_ff)
         OP_OPEN:        match = (owner_val == '0);
         OP_CLOSE_OWNER: match = (owner_val == op_owner_ff);
         OP_BIND:        match = (port_val == cand_ff);
         default:        match = 1'b0;
      endcase

      sts.kind       = op_kind_ff;
      sts.owner_zero = (op_owner_ff == '0);
      sts.slot_ok    = (32'(op_slot_ff) < SLOTS_U);
      sts.preq_zero  = (op_preq_ff == '0);
      sts.hit        = dv_ff && match;
      sts.last       = dv_ff && (rd_idx_ff == IDX_W'(SLOTS - 1));
      sts.hash_done  = hash_done;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_kind_in  = op_kind_ff;
      op_owner_in = op_owner_ff;
      op_slot_in  = op_slot_ff;
      op_preq_in  = op_preq_ff;
      op_time_in  = op_time_ff;
      if (cmd.load) begin
         op_kind_in  = op_kind_type'(req_kind);
         op_owner_in = req_owner_id;
         op_slot_in  = req_slot;
         op_preq_in  = req_port_request;
         op_time_in  = req_time_value;
      end

      cand_in = cand_ff;
      if (cmd.cand_req) begin
         cand_in = op_preq_ff;
      end else if (cmd.cand_hash) begin
         cand_in = EPH_BASE | PORT_W'(hash[EPH_BITS-1:0]);
      end

      issue_in   = issue_ff;
      iss_idx_in = iss_idx_ff;
      if (cmd.scan_start) begin
         issue_in   = 1'b1;
         iss_idx_in = '0;
      end else if (cmd.scan_stop) begin
         issue_in = 1'b0;
      end else if (issue_ff) begin
         if (iss_idx_ff == IDX_W'(SLOTS - 1)) begin
            issue_in = 1'b0;
         end
         iss_idx_in = iss_idx_ff + 1'b1;
      end
      dv_in = issue_ff && !cmd.scan_stop;

      own_vld_in  = own_vld_ff;
      port_vld_in = port_vld_ff;
      if (cmd.wr_open) begin
         own_vld_in[rd_idx_ff]  = 1'b1;
         port_vld_in[rd_idx_ff] = 1'b0;
      end
      if (cmd.clr_hit) begin
         own_vld_in[rd_idx_ff]  = 1'b0;
         port_vld_in[rd_idx_ff] = 1'b0;
      end
      if (cmd.clr_slot) begin
         own_vld_in[slot_addr]  = 1'b0;
         port_vld_in[slot_addr] = 1'b0;
      end
      if (cmd.wr_bind) begin
         port_vld_in[slot_addr] = 1'b1;
      end

      res_ok_in   = res_ok_ff;
      res_slot_in = res_slot_ff;
      res_port_in = res_port_ff;
      if (cmd.res_wr) begin
         res_ok_in   = cmd.res_ok;
         res_slot_in = (cmd.res_ok && (op_kind_ff == OP_OPEN)) ? SLOT_W'(rd_idx_ff) : '0;
         res_port_in = (cmd.res_ok && (op_kind_ff == OP_BIND)) ? cand_ff : '0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_port_in  = rsp_port_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_slot_in  = res_slot_ff;
         rsp_port_in  = res_port_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         iss_idx_ff   <= '0;
         dv_ff        <= 1'b0;
         own_vld_ff   <= '0;
         port_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         issue_ff     <= issue_in;
         iss_idx_ff   <= iss_idx_in;
         dv_ff        <= dv_in;
         own_vld_ff   <= own_vld_in;
         port_vld_ff  <= port_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_kind_ff  <= op_kind_in;
      op_owner_ff <= op_owner_in;
      op_slot_ff  <= op_slot_in;
      op_preq_ff  <= op_preq_in;
      op_time_ff  <= op_time_in;
      cand_ff     <= cand_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      res_port_ff <= res_port_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_port_ff <= rsp_port_in;
   end

   // Memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (cmd.wr_open) begin
         own_mem[rd_idx_ff] <= op_owner_ff;
      end
      if (cmd.wr_bind) begin
         port_mem[slot_addr] <= cand_ff;
      end
      rd_idx_ff  <= iss_idx_ff;
      own_rd_ff  <= own_mem[iss_idx_ff];
      port_rd_ff <= port_mem[iss_idx_ff];
      own_rv_ff  <= own_vld_ff[iss_idx_ff];
      port_rv_ff <= port_vld_ff[iss_idx_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_port_out = rsp_port_ff;

   a_one_table_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_open, cmd.clr_slot, cmd.clr_hit, cmd.wr_bind}))
      else $error("more than one table update in a cycle");

   a_scan_not_restarted: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !issue_ff)
      else $error("scan restarted while a sweep is in flight");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_slot_ff == '0 && rsp_port_ff == '0))
      else $error("failed result carries a slot or port");

endmodule
`default_nettype wire

// ===== rtl/sspt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Socket slot table controller
// Sequences each operation: dispatch, slot scans, hash rounds with retry
// counting, and the hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module sspt_ctrl
   import sspt_pkg::*;
#(
   parameter int MAX_TRIES = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire sspt_sts_type sts,
   output sspt_cmd_type      cmd
);

   localparam int TRY_W = $clog2(MAX_TRIES + 1);

   ctrl_state_type   state_ff, state_in;
   logic [TRY_W-1:0] try_ff, try_in;

   always_comb begin
      state_in  = state_ff;
      try_in    = try_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.kind)
               OP_OPEN: begin
                  if (sts.owner_zero) begin
                     cmd.res_wr = 1'b1;
                     state_in   = ST_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_OPEN_SCAN;
                  end
               end
               OP_CLOSE: begin
                  cmd.clr_slot = sts.slot_ok;
                  cmd.res_wr   = 1'b1;
                  cmd.res_ok   = sts.slot_ok;
                  state_in     = ST_RESP;
               end
               OP_CLOSE_OWNER: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_OWNER_SCAN;
               end
               OP_BIND: begin
                  if (!sts.slot_ok) begin
                     cmd.res_wr = 1'b1;
                     state_in   = ST_RESP;
                  end else if (!sts.preq_zero) begin
                     cmd.cand_req   = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in       = ST_PORT_SCAN;
                  end else begin
                     cmd.hash_start = 1'b1;
                     try_in         = '0;
                     state_in       = ST_HASH;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_OPEN_SCAN: begin
            if (sts.hit) begin
               cmd.wr_open   = 1'b1;
               cmd.scan_stop = 1'b1;
               cmd.res_wr    = 1'b1;
               cmd.res_ok    = 1'b1;
               state_in      = ST_RESP;
            end else if (sts.last) begin
               cmd.res_wr = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_OWNER_SCAN: begin
            cmd.clr_hit = sts.hit;
            if (sts.last) begin
               cmd.res_wr = 1'b1;
               cmd.res_ok = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_HASH: begin
            if (sts.hash_done) begin
               cmd.cand_hash  = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_PORT_SCAN;
            end
         end
         ST_PORT_SCAN: begin
            if (sts.hit) begin
               cmd.scan_stop = 1'b1;
               if (sts.preq_zero && (try_ff < TRY_W'(MAX_TRIES - 1))) begin
                  cmd.hash_start  = 1'b1;
                  cmd.hash_reseed = 1'b1;
                  try_in          = try_ff + 1'b1;
                  state_in        = ST_HASH;
               end else begin
                  cmd.res_wr = 1'b1;
                  state_in   = ST_RESP;
               end
            end else if (sts.last) begin
               cmd.wr_bind = 1'b1;
               cmd.res_wr  = 1'b1;
               cmd.res_ok  = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         try_ff   <= '0;
      end else begin
         state_ff <= state_in;
         try_ff   <= try_in;
      end
   end

   a_result_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.res_wr |=> (state_ff == ST_RESP))
      else $error("result recorded without moving to the response state");

   a_hash_done_waited: assert property (@(posedge clock) disable iff (reset)
      sts.hash_done |-> (state_ff == ST_HASH))
      else $error("hash round finished while the controller was not waiting");

   a_try_in_range: assert property (@(posedge clock) disable iff (reset)
      try_ff < TRY_W'(MAX_TRIES))
      else $error("retry count ran past the try limit");

endmodule
`default_nettype wire

// ===== rtl/socket_slot_and_port_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Socket slot and port table
// Slot table with owner ids and local port binding, including ephemeral
// port selection by hash with retries.
// ----------------------------------------------------------------------------
// Each request word performs one operation and produces exactly one response
// word. Open claims the lowest free slot for a nonzero owner, close frees one
// slot, close-by-owner frees every slot of an owner, and bind gives a slot a
// local port unless some slot already holds it; a requested port of zero
// selects an ephemeral port from a hash of the time input, rehashing on each
// collision for up to MAX_TRIES hashes in all. The block handles one
// request at a time. Every search walks the slot memories one entry per
// cycle, so timing is set by that scan and by the shared multiplier of the
// hash unit. A new request is taken as soon as the previous one has finished
// its work, even while its response word still waits in the output register.
// The table is empty right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module socket_slot_and_port_table
   import sspt_pkg::*;
#(
   parameter int SLOTS     = 32,
   parameter int MAX_TRIES = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [KIND_W-1:0]  req_kind,
   input  wire logic [OWNER_W-1:0] req_owner_id,
   input  wire logic [SLOT_W-1:0]  req_slot,
   input  wire logic [PORT_W-1:0]  req_port_request,
   input  wire logic [TIME_W-1:0]  req_time_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic [SLOT_W-1:0]       rsp_slot_out,
   output logic [PORT_W-1:0]       rsp_port_out
);

   // The controller and the datapath talk only through these two bundles.
   sspt_cmd_type cmd;
   sspt_sts_type sts;

   sspt_ctrl #(
      .MAX_TRIES (MAX_TRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sspt_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_owner_id     (req_owner_id),
      .req_slot         (req_slot),
      .req_port_request (req_port_request),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_port_out     (rsp_port_out)
   );

endmodule
`default_nettype wire

// ===== sim/socket_slot_and_port_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Socket slot and port table testbench
// Drives open, close, close-by-owner and bind words into the table under
// random sender bursts and receiver stalls. A scoreboard keeps its own copy
// of the slot owners and bound ports, works out the response word for every
// accepted request word and checks each response word against it in order.
// ----------------------------------------------------------------------------
module socket_slot_and_port_table_tb;
   import sspt_pkg::*;

   localparam int SLOTS        = 32;
   localparam int MAX_TRIES    = 8;
   localparam int RANDOM_ITEMS = 900;
   localparam int FILL_OPENS   = SLOTS + 4;
   // Guard against a hung handshake. The slowest correct run stays well
   // below this even if every word were an ephemeral bind using all tries.
   localparam int unsigned RUN_LIMIT = 2_000_000;
   // Quiet cycles at the end, long enough for the slowest bind to finish.
   localparam int TAIL_CYCLES = MAX_TRIES * (SLOTS + 10);

   typedef struct packed {
      op_kind_type        kind;
      logic [OWNER_W-1:0] owner_id;
      logic [SLOT_W-1:0]  slot;
      logic [PORT_W-1:0]  port_request;
      logic [TIME_W-1:0]  time_value;
   } table_cmd_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot_out;
      logic [PORT_W-1:0] port_out;
   } table_reply_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the slot table plus the queue of response words
   // that are still owed by the block.
   // -------------------------------------------------------------------------
   class socket_table_scoreboard;
      logic [OWNER_W-1:0] owner_of [SLOTS];
      logic [PORT_W-1:0]  port_of  [SLOTS];
      table_reply_type    expected_q[$];
      int                 mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            owner_of[i] = '0;
            port_of[i]  = '0;
         end
         mismatches = 0;
      endfunction

      // One round of the xorshift-multiply hash used for ephemeral ports.
      function logic [63:0] mix_seed(logic [63:0] s);
         logic [63:0] x;
         x = s ^ (s >> 12);
         x = x ^ (x << 25);
         x = x ^ (x >> 27);
         return x * HASH_MUL;
      endfunction

      // A port counts as taken if any slot holds it, the target slot too.
      function bit port_held(logic [PORT_W-1:0] p);
         bit held;
         held = 1'b0;
         for (int i = 0; i < SLOTS; i++)
            if (port_of[i] == p) held = 1'b1;
         return held;
      endfunction

      function void note_request(table_cmd_type cmd);
         table_reply_type   res;
         logic [63:0]       s;
         logic [63:0]       h;
         logic [PORT_W-1:0] cand;
         res = '0;
         case (cmd.kind)
            OP_OPEN: begin
               // Owner zero means free, so it can never claim a slot.
               if (cmd.owner_id != '0) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!res.ok && owner_of[i] == '0) begin
                        owner_of[i]  = cmd.owner_id;
                        port_of[i]   = '0;
                        res.ok       = 1'b1;
                        res.slot_out = SLOT_W'(i);
                     end
                  end
               end
            end
            OP_CLOSE: begin
               if (int'(cmd.slot) < SLOTS) begin
                  owner_of[cmd.slot] = '0;
                  port_of[cmd.slot]  = '0;
                  res.ok             = 1'b1;
               end
            end
            OP_CLOSE_OWNER: begin
               // With owner zero this only wipes the ports of free slots.
               for (int i = 0; i < SLOTS; i++) begin
                  if (owner_of[i] == cmd.owner_id) begin
                     owner_of[i] = '0;
                     port_of[i]  = '0;
                  end
               end
               res.ok = 1'b1;
            end
            default: begin
               // Bind does not look at ownership; free slots bind as well.
               if (int'(cmd.slot) < SLOTS) begin
                  if (cmd.port_request != '0) begin
                     if (!port_held(cmd.port_request)) begin
                        port_of[cmd.slot] = cmd.port_request;
                        res.ok            = 1'b1;
                        res.port_out      = cmd.port_request;
                     end
                  end else begin
                     s = cmd.time_value;
                     for (int t = 0; t < MAX_TRIES; t++) begin
                        if (!res.ok) begin
                           h    = mix_seed(s);
                           cand = EPH_BASE | {{(PORT_W-EPH_BITS){1'b0}}, h[EPH_BITS-1:0]};
                           if (!port_held(cand)) begin
                              port_of[cmd.slot] = cand;
                              res.ok            = 1'b1;
                              res.port_out      = cand;
                           end
                           s = h;
                        end
                     end
                  end
               end
            end
         endcase
         expected_q.push_back(res);
      endfunction

      function void check_response(table_reply_type got);
         table_reply_type want;
         if (expected_q.size() == 0) begin
            $error("response word with nothing outstanding: ok=%0b slot_out=%0d port_out=%0h",
                   got.ok, got.slot_out, got.port_out);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (got.ok !== want.ok) begin
               $error("ok: expected %0b, actual %0b", want.ok, got.ok);
               mismatches++;
            end
            if (got.slot_out !== want.slot_out) begin
               $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
               mismatches++;
            end
            if (got.port_out !== want.port_out) begin
               $error("port_out: expected %0h, actual %0h", want.port_out, got.port_out);
               mismatches++;
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_kind         = '0;
   logic [OWNER_W-1:0] req_owner_id     = '0;
   logic [SLOT_W-1:0]  req_slot         = '0;
   logic [PORT_W-1:0]  req_port_request = '0;
   logic [TIME_W-1:0]  req_time_value   = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic               rsp_ok;
   logic [SLOT_W-1:0]  rsp_slot_out;
   logic [PORT_W-1:0]  rsp_port_out;

   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   int          burst_left  = 0;

   socket_table_scoreboard sb = new();

   always #5 clock = ~clock;

   socket_slot_and_port_table #(
      .SLOTS     (SLOTS),
      .MAX_TRIES (MAX_TRIES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_owner_id     (req_owner_id),
      .req_slot         (req_slot),
      .req_port_request (req_port_request),
      .req_time_value   (req_time_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_port_out     (rsp_port_out)
   );

   // Runaway guard. Ends the run with the failure line if the handshakes
   // never finish.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("socket_slot_and_port_table_tb: done, errors");
         $finish;
      end
   end

   // The receiver rotates through four stall habits: always ready, random
   // stalls, a fixed on/off rhythm, and rare long stalls.
   always @(posedge clock) begin
      case ((cycle_count / 256) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ((cycle_count % 9) < 4);
         default: begin
            if (stall_left != 0) begin
               stall_left <= stall_left - 1;
               rsp_ready  <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(5, 20);
            end
         end
      endcase
   end

   // Both channels are sampled at the rising edge, where every testbench and
   // block signal still holds its value from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request('{op_kind_type'(req_kind), req_owner_id, req_slot,
                              req_port_request, req_time_value});
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_ok, rsp_slot_out, rsp_port_out});
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Presents one request word and returns at the edge that accepts it. Valid
   // is left high so a following word goes out back to back.
   task automatic send_word(table_cmd_type cmd);
      req_valid        <= 1'b1;
      req_kind         <= cmd.kind;
      req_owner_id     <= cmd.owner_id;
      req_slot         <= cmd.slot;
      req_port_request <= cmd.port_request;
      req_time_value   <= cmd.time_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds off until the block owes no more response words. The first edge
   // lets the monitor record the word accepted just before.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Sends in bursts of random length. Between bursts there is usually a
   // random gap, sometimes none at all.
   task automatic send_in_burst(table_cmd_type cmd);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
      burst_left--;
      send_word(cmd);
   endtask

   task automatic issue(op_kind_type kind, logic [OWNER_W-1:0] owner,
                        logic [SLOT_W-1:0] slot, logic [PORT_W-1:0] port,
                        logic [TIME_W-1:0] seed);
      send_word('{kind, owner, slot, port, seed});
   endtask

   // Random word. Owners and ports come mostly from small pools, and seeds
   // often repeat, so that ports collide and hash chains fill up.
   function automatic table_cmd_type random_cmd();
      table_cmd_type       cmd;
      int unsigned         roll;
      logic [PORT_W-1:0]   port_pool [8];
      logic [TIME_W-1:0]   seed_pool [4];
      port_pool = '{16'h0001, 16'd80, 16'd443, 16'd8080,
                    16'h7FFF, 16'h8000, 16'hFFFF, 16'hAAAA};
      seed_pool = '{64'h0, 64'h1, 64'hDEAD_BEEF_0123_4567, '1};
      roll = $urandom_range(0, 99);
      if (roll < 34)      cmd.kind = OP_OPEN;
      else if (roll < 48) cmd.kind = OP_CLOSE;
      else if (roll < 55) cmd.kind = OP_CLOSE_OWNER;
      else                cmd.kind = OP_BIND;
      roll = $urandom_range(0, 9);
      if (roll < 7)       cmd.owner_id = OWNER_W'($urandom_range(1, 6));
      else if (roll == 7) cmd.owner_id = '0;
      else                cmd.owner_id = OWNER_W'($urandom_range(0, 65535));
      cmd.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
      roll = $urandom_range(0, 9);
      if (roll < 4)      cmd.port_request = '0;
      else if (roll < 8) cmd.port_request = port_pool[$urandom_range(0, 7)];
      else               cmd.port_request = PORT_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 0) cmd.time_value = seed_pool[$urandom_range(0, 3)];
      else                           cmd.time_value = {$urandom, $urandom};
      return cmd;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Owner zero is refused, then the owner and port
      // extremes, a port already taken by another slot and by the target
      // slot itself, a bind to a free slot, and an ephemeral bind that runs
      // out of tries after eight slots have taken its whole hash chain.
      issue(OP_OPEN, '0, '0, '0, '0);
      issue(OP_CLOSE, '0, '0, '0, '0);
      issue(OP_OPEN, '1, '1, '1, '1);
      issue(OP_OPEN, 16'd1, '0, '0, '0);
      issue(OP_BIND, '0, 5'd0, '1, '0);
      issue(OP_BIND, '0, 5'd1, '1, '0);
      issue(OP_BIND, '0, 5'd0, '1, '0);
      issue(OP_BIND, '0, 5'd31, 16'd1, '0);
      for (int i = 2; i <= 10; i++)
         issue(OP_BIND, '0, SLOT_W'(i), '0, '1);
      issue(OP_BIND, '0, 5'd11, '0, '0);
      issue(OP_CLOSE, '0, 5'd0, '0, '0);
      issue(OP_CLOSE, '1, 5'd31, '1, '1);
      // Owner zero only matches free slots, which clears the ports bound
      // to them above.
      issue(OP_CLOSE_OWNER, '0, '0, '0, '0);
      issue(OP_CLOSE_OWNER, '1, '0, '0, '0);
      issue(OP_CLOSE_OWNER, 16'd1, '0, '0, '0);

      // Random part. Now and then a run of opens fills the table past full,
      // and twice the sender waits for every response word to come back.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 180 == 90) begin
            for (int k = 0; k < FILL_OPENS; k++)
               send_in_burst('{OP_OPEN, OWNER_W'($urandom_range(1, 6)),
                               SLOT_W'($urandom_range(0, SLOTS - 1)),
                               PORT_W'($urandom_range(0, 65535)), {$urandom, $urandom}});
         end
         if (n == 300 || n == 650) wait_for_drain();
         send_in_burst(random_cmd());
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("socket_slot_and_port_table_tb: done, clean");
      else
         $display("socket_slot_and_port_table_tb: done, errors");
      $finish;
   end

endmodule
